>>> sv/zph_pkg.sv
// Shared constants, request and command codes, and the command record for
// the Zobrist position hash block. No dependencies.
package zph_pkg;

    localparam int SQUARES          = 64;
    localparam int CASTLE_STATES    = 16;
    localparam int PIECE_KINDS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // req_type codes on the input channel
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_PIECE  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // command codes carried through the queue
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_PIECE  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  index;
        logic [63:0] data;
        logic [3:0]  kind;
        logic        ep_valid;
        logic [5:0]  ep_sq;
        logic [3:0]  rights;
        logic        black;
    } cmd_t;

    // piece keys, en passant keys, castling keys, side key
    function automatic int key_count(input int piece_kinds);
        return piece_kinds * SQUARES + SQUARES + CASTLE_STATES + 1;
    endfunction

endpackage

>>> sv/zobrist_position_hash.sv
// Zobrist position hash: top level joining front end, command queue and hash engine.
// Uses zph_pkg, zph_front, zph_queue and zph_engine.
//
// Load the key table with write beats (req_type 0) at key_index
// piece*64+square for the piece keys, then 64 en passant keys, 16 castling
// keys and one side key; writes beyond the table are dropped. Hash a position
// with one piece beat (req_type 1) per piece kind and close it with a finish
// beat (req_type 2), which returns one hash beat and clears the running hash.
// Request beats enter a queue of QUEUE_DEPTH commands, so the request side
// keeps moving while the engine works or the hash side stalls, until the queue
// is full. The engine owns the single read port of the key table and takes one
// command at a time: a write goes into the table, a piece beat scans squares up
// to its highest set square, a finish folds in the en passant, castling and side
// keys and waits out any stall on the hash side. Beats that change nothing
// (unused req_type, foreign piece kind, empty mask) never enter the queue.
// Keys that are read before being written give an undefined hash.
module zobrist_position_hash #(
    parameter int PIECE_KINDS = zph_pkg::PIECE_KINDS_DEF,
    parameter int QUEUE_DEPTH = zph_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [9:0]  key_index,
    input  logic [63:0] key_value,
    input  logic [3:0]  piece_kind,
    input  logic [63:0] occupancy,
    input  logic [6:0]  ep_square,
    input  logic [3:0]  castle_rights,
    input  logic        black_to_move,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [63:0] hash
);

    logic          push;
    logic          queue_full;
    logic          queue_empty;
    logic          pop;
    zph_pkg::cmd_t push_cmd;
    zph_pkg::cmd_t head;

    // classify request beats and hold them off while the queue is full
    zph_front #(
        .PIECE_KINDS (PIECE_KINDS)
    ) u_front (
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .key_index     (key_index),
        .key_value     (key_value),
        .piece_kind    (piece_kind),
        .occupancy     (occupancy),
        .ep_square     (ep_square),
        .castle_rights (castle_rights),
        .black_to_move (black_to_move),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    // decouple intake from the engine
    zph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    // advance commands in order through the key table and running hash
    zph_engine #(
        .PIECE_KINDS (PIECE_KINDS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .hash_valid  (hash_valid),
        .hash_stall  (hash_stall),
        .hash        (hash)
    );

endmodule

>>> sv/zph_front.sv
// Front end of the Zobrist hash block: accepts request beats, drops requests
// that have no effect and turns the rest into queue commands. Uses zph_pkg.
module zph_front #(
    parameter int PIECE_KINDS = zph_pkg::PIECE_KINDS_DEF
) (
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        req_type,
    input  logic [9:0]        key_index,
    input  logic [63:0]       key_value,
    input  logic [3:0]        piece_kind,
    input  logic [63:0]       occupancy,
    input  logic [6:0]        ep_square,
    input  logic [3:0]        castle_rights,
    input  logic              black_to_move,
    input  logic              queue_full,
    output logic              push,
    output zph_pkg::cmd_t     cmd
);

    localparam int KEY_COUNT = zph_pkg::key_count(PIECE_KINDS);
    localparam int KC_W      = $clog2(KEY_COUNT + 1);
    localparam int IDX_CMP_W = (KC_W > 10) ? KC_W : 10;

    logic       index_ok;
    logic       kind_ok;
    logic       keep;
    logic [1:0] op_sel;

    assign req_stall = queue_full;

    assign index_ok = IDX_CMP_W'(key_index) < IDX_CMP_W'(KEY_COUNT);
    assign kind_ok  = 5'(piece_kind) < 5'(PIECE_KINDS);

    // drop writes out of range, foreign piece kinds, empty masks, unused codes
    always_comb
    begin
        keep   = 1'b0;
        op_sel = zph_pkg::OP_FINISH;
        case (req_type)
            zph_pkg::REQ_WRITE:
            begin
                keep   = index_ok;
                op_sel = zph_pkg::OP_WRITE;
            end
            zph_pkg::REQ_PIECE:
            begin
                keep   = kind_ok && (occupancy != 64'd0);
                op_sel = zph_pkg::OP_PIECE;
            end
            zph_pkg::REQ_FINISH:
            begin
                keep   = 1'b1;
                op_sel = zph_pkg::OP_FINISH;
            end
            default:
            begin
                keep   = 1'b0;
                op_sel = zph_pkg::OP_FINISH;
            end
        endcase
    end

    assign cmd.op       = op_sel;
    assign cmd.index    = key_index;
    assign cmd.data     = (req_type == zph_pkg::REQ_WRITE) ? key_value : occupancy;
    assign cmd.kind     = piece_kind;
    assign cmd.ep_valid = ep_square < 7'(zph_pkg::SQUARES);
    assign cmd.ep_sq    = ep_square[5:0];
    assign cmd.rights   = castle_rights;
    assign cmd.black    = black_to_move;

    assign push = req_valid && !queue_full && keep;

endmodule

>>> sv/zph_queue.sv
// Small command queue between the front end and the hash engine of the
// Zobrist hash block. Uses zph_pkg for the command record.
module zph_queue #(
    parameter int DEPTH = zph_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  zph_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output zph_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zph_pkg::cmd_t    q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> sv/zph_engine.sv
// Hash engine of the Zobrist hash block: key table memory, running hash,
// square scan and finish sequence, result register. Uses zph_pkg.
module zph_engine #(
    parameter int PIECE_KINDS = zph_pkg::PIECE_KINDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          queue_empty,
    input  zph_pkg::cmd_t head,
    output logic          pop,
    output logic          hash_valid,
    input  logic          hash_stall,
    output logic [63:0]   hash
);

    localparam int KEY_COUNT   = zph_pkg::key_count(PIECE_KINDS);
    localparam int AW          = $clog2(KEY_COUNT);
    localparam int EP_BASE     = PIECE_KINDS * zph_pkg::SQUARES;
    localparam int CASTLE_BASE = EP_BASE + zph_pkg::SQUARES;
    localparam int SIDE_SLOT   = CASTLE_BASE + zph_pkg::CASTLE_STATES;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_EP     = 3'd2;
    localparam logic [2:0] ST_CASTLE = 3'd3;
    localparam logic [2:0] ST_SIDE   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [63:0]   key_mem [KEY_COUNT];

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [63:0]   mask_reg;
    logic [63:0]   mask_next;
    logic [5:0]    sq_reg;
    logic [5:0]    sq_next;
    logic [3:0]    kind_reg;
    logic          ep_valid_reg;
    logic [5:0]    ep_sq_reg;
    logic [3:0]    rights_reg;
    logic          black_reg;
    logic [63:0]   acc_reg;
    logic [63:0]   acc_next;
    logic [63:0]   acc_fold;
    logic          rd_pend_reg;
    logic [63:0]   rd_data_reg;
    logic [63:0]   hash_reg;
    logic          hash_valid_reg;
    logic          hash_valid_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          load;
    logic          emit;

    assign hash       = hash_reg;
    assign hash_valid = hash_valid_reg;

    assign pop   = (state_reg == ST_IDLE) && !queue_empty;
    assign wr_en = pop && (head.op == zph_pkg::OP_WRITE);
    assign load  = pop && (head.op != zph_pkg::OP_WRITE);
    assign emit  = (state_reg == ST_EMIT) && (!hash_valid_reg || !hash_stall);

    // fold in the key read last cycle
    assign acc_fold = rd_pend_reg ? (acc_reg ^ rd_data_reg) : acc_reg;
    assign acc_next = emit ? 64'd0 : acc_fold;

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        sq_next    = sq_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.op)
                        zph_pkg::OP_PIECE:
                        begin
                            state_next = ST_SCAN;
                            mask_next  = head.data;
                            sq_next    = '0;
                        end
                        zph_pkg::OP_FINISH:
                        begin
                            state_next = ST_EP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en     = mask_reg[0];
                rd_addr   = AW'({kind_reg, sq_reg});
                mask_next = mask_reg >> 1;
                sq_next   = sq_reg + 1'b1;
                if (mask_next == 64'd0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EP:
            begin
                rd_en      = ep_valid_reg;
                rd_addr    = AW'(EP_BASE) + AW'(ep_sq_reg);
                state_next = ST_CASTLE;
            end
            ST_CASTLE:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(CASTLE_BASE) + AW'(rights_reg);
                state_next = ST_SIDE;
            end
            ST_SIDE:
            begin
                rd_en      = black_reg;
                rd_addr    = AW'(SIDE_SLOT);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hash_valid_next = hash_valid_reg;
        if (!hash_stall)
        begin
            hash_valid_next = 1'b0;
        end
        if (emit)
        begin
            hash_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            acc_reg        <= 64'd0;
            rd_pend_reg    <= 1'b0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            rd_pend_reg    <= rd_en;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        sq_reg   <= sq_next;
        if (load)
        begin
            kind_reg     <= head.kind;
            ep_valid_reg <= head.ep_valid;
            ep_sq_reg    <= head.ep_sq;
            rights_reg   <= head.rights;
            black_reg    <= head.black;
        end
        if (emit)
        begin
            hash_reg <= acc_fold;
        end
    end

    // key table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[AW'(head.index)] <= head.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> ({1'b0, rd_addr} < (AW + 1)'(KEY_COUNT)))
        else $error("key table read out of range");
    a_scan_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (mask_reg != 64'd0))
        else $error("scan running on an empty mask");
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (acc_reg == 64'd0) && hash_valid_reg)
        else $error("running hash not cleared after emit");

endmodule
